/* src/glci_pkg.sv */
package glci_pkg;

  // Item field widths
  localparam int COORD_BITS  = 8;
  localparam int WGT_BITS    = 16;
  localparam int COST_BITS   = 40;
  localparam int STATUS_BITS = 2;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_OFF_GRID  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ABOVE_MAX = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BELOW_MIN = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_WEIGHT = 2'd2;
  localparam logic [1:0] REG_MAX_WEIGHT = 2'd3;

  // 1.42 in Q1.16
  localparam logic [16:0] DIAG_SCALE = 17'd93061;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [WGT_BITS-1:0]   new_weight;
    logic                  overwrite_mode;
  } in_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0]   line_cost;
    logic [STATUS_BITS-1:0] status;
  } out_item_t;

endpackage

/* src/glci_in_if.sv */
interface glci_in_if;
  logic               valid;
  logic               ready;
  glci_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/glci_out_if.sv */
interface glci_out_if;
  logic                valid;
  logic                ready;
  glci_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/glci_grid_ram.sv */
module glci_grid_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/grid_line_cost_integrator_core.sv */
// Grid line-cost integrator.
// Input beats on in_ch are either a cell write (action 0) or a line query
// (action 1); every input beat yields exactly one result beat on out_ch
// carrying line_cost (Q32.8) and a status code. Registers map_width,
// map_height, min_weight and max_weight sit on the APB port at 0x0..0xC.
// A query walks the line cell by cell along the major axis; a line that is
// neither straight nor 45 degrees adds a slope divide and a square root, and
// a crossing-fraction divide at each row crossing. All of this runs on one
// sequencer with a single restoring divider and a single-port grid read, so
// one item is in flight at a time.
// After reset the grid is swept to zero, one cell per cycle, over all
// GRID_WIDTH*GRID_HEIGHT cells (65536 by default); in_ch.ready stays low
// during the sweep, while register writes are taken throughout.
// The result sits in an output register: a stalled receiver holds it, and
// the next input beat is still accepted and worked on meanwhile; only the
// following result waits for the register to free up.
module grid_line_cost_integrator_core #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  glci_in_if.sink           in_ch,
  glci_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [15:0] W_CAP = 16'((32'd1 << WEIGHT_BITS) - 1);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_CHECK     = 5'd2;
  localparam logic [4:0] S_WR_RD     = 5'd3;
  localparam logic [4:0] S_WR_UPD    = 5'd4;
  localparam logic [4:0] S_SETUP     = 5'd5;
  localparam logic [4:0] S_DIV       = 5'd6;
  localparam logic [4:0] S_SQ        = 5'd7;
  localparam logic [4:0] S_SQRT      = 5'd8;
  localparam logic [4:0] S_START_RD  = 5'd9;
  localparam logic [4:0] S_START_ACC = 5'd10;
  localparam logic [4:0] S_STEP_RD   = 5'd11;
  localparam logic [4:0] S_STEP_ACC  = 5'd12;
  localparam logic [4:0] S_CROSS1    = 5'd13;
  localparam logic [4:0] S_CROSS2    = 5'd14;
  localparam logic [4:0] S_END_ACC   = 5'd15;
  localparam logic [4:0] S_SCALE1    = 5'd16;
  localparam logic [4:0] S_SCALE2    = 5'd17;
  localparam logic [4:0] S_DONE      = 5'd18;

  localparam logic [1:0] MODE_AXIS = 2'd0;
  localparam logic [1:0] MODE_DIAG = 2'd1;
  localparam logic [1:0] MODE_DDA  = 2'd2;

  // cell (x,y) lives at y*GRID_WIDTH+x
  function automatic logic [AW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
    cell_addr = AW'(32'(y) * GRID_WIDTH + 32'(x));
  endfunction

  // ---------------- registers ----------------
  logic [4:0]               state_r, state_nxt;
  glci_pkg::in_item_t       item_r, item_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic                     xmaj_r, xmaj_nxt;
  logic                     sm_neg_r, sm_neg_nxt;
  logic [8:0]               p_r, p_nxt;
  logic [7:0]               p1_r, p1_nxt;
  logic [7:0]               n_r, n_nxt;
  logic [15:0]              mq_r, mq_nxt;
  logic signed [17:0]       err_r, err_nxt;
  logic [39:0]              sum_r, sum_nxt;
  logic [16:0]              scale_r, scale_nxt;
  logic [33:0]              sqv_r, sqv_nxt;
  logic [33:0]              sqr_r, sqr_nxt;
  logic [33:0]              sqb_r, sqb_nxt;
  logic [15:0]              div_rem_r, div_rem_nxt;
  logic [16:0]              div_nb_r, div_nb_nxt;
  logic [16:0]              div_q_r, div_q_nxt;
  logic [15:0]              div_d_r, div_d_nxt;
  logic [4:0]               div_cnt_r, div_cnt_nxt;
  logic                     div_for_t_r, div_for_t_nxt;
  logic [15:0]              w_hold_r, w_hold_nxt;
  logic [16:0]              t_r, t_nxt;
  logic [40:0]              prod_r, prod_nxt;
  logic [39:0]              res_cost_r, res_cost_nxt;
  logic [1:0]               res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  glci_pkg::out_item_t      out_data_r, out_data_nxt;
  logic [8:0]               map_width_r, map_width_nxt;
  logic [8:0]               map_height_r, map_height_nxt;
  logic [15:0]              min_weight_r, min_weight_nxt;
  logic [15:0]              max_weight_r, max_weight_nxt;

  // ---------------- grid memory ----------------
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic [15:0]            rd_w;

  glci_grid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (WEIGHT_BITS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_w = 16'(ram_rdata);

  // ---------------- config port ----------------
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    min_weight_nxt = min_weight_r;
    max_weight_nxt = max_weight_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        glci_pkg::REG_MAP_WIDTH:  map_width_nxt  = pwdata[8:0];
        glci_pkg::REG_MAP_HEIGHT: map_height_nxt = pwdata[8:0];
        glci_pkg::REG_MIN_WEIGHT: min_weight_nxt = pwdata[15:0];
        glci_pkg::REG_MAX_WEIGHT: max_weight_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      glci_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width_r);
      glci_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height_r);
      glci_pkg::REG_MIN_WEIGHT: prdata = 32'(min_weight_r);
      glci_pkg::REG_MAX_WEIGHT: prdata = 32'(max_weight_r);
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---------------- datapath helpers ----------------
  logic [7:0]  sx, sy, ex, ey;
  logic        off_s, off_e;
  logic [15:0] w_hi;
  logic [7:0]  adx, ady, major, minor;
  logic [7:0]  n_step, n_use;
  logic        walk_more;
  logic [7:0]  rd_x, rd_y, rd_p, rd_n;
  logic [16:0] div_r2;
  logic        div_ge;
  logic [16:0] div_q_new;
  logic [33:0] sq_rb;
  logic [33:0] sqr_new;
  logic signed [18:0] err_mq;
  logic signed [18:0] num_s;
  logic [16:0] t_sat;

  assign sx = item_r.start_x;
  assign sy = item_r.start_y;
  assign ex = item_r.end_x;
  assign ey = item_r.end_y;

  // active grid is min(register, grid size)
  assign off_s = ({1'b0, sx} >= map_width_r) || (32'(sx) >= GRID_WIDTH)
              || ({1'b0, sy} >= map_height_r) || (32'(sy) >= GRID_HEIGHT);
  assign off_e = ({1'b0, ex} >= map_width_r) || (32'(ex) >= GRID_WIDTH)
              || ({1'b0, ey} >= map_height_r) || (32'(ey) >= GRID_HEIGHT);
  assign w_hi  = (max_weight_r < W_CAP) ? max_weight_r : W_CAP;

  assign adx   = (sx > ex) ? sx - ex : ex - sx;
  assign ady   = (sy > ey) ? sy - ey : ey - sy;
  assign major = (ady < adx) ? adx : ady;
  assign minor = (ady < adx) ? ady : adx;

  assign n_step    = sm_neg_r ? n_r - 8'd1 : n_r + 8'd1;
  assign n_use     = (mode_r == MODE_DIAG) ? n_step : n_r;
  assign walk_more = (p_r < {1'b0, p1_r});

  // read address mux
  always_comb begin
    rd_p = p_r[7:0];
    rd_n = n_r;
    case (state_r)
      S_STEP_RD: begin
        rd_p = walk_more ? p_r[7:0] : p1_r;
        rd_n = n_use;
      end
      S_CROSS1: rd_n = n_step;
      default: ;
    endcase
    if (state_r == S_WR_RD) begin
      rd_x = sx;
      rd_y = sy;
    end else begin
      rd_x = xmaj_r ? rd_p : rd_n;
      rd_y = xmaj_r ? rd_n : rd_p;
    end
  end
  assign ram_raddr = cell_addr(rd_x, rd_y);

  // restoring divider step
  assign div_r2    = {div_rem_r, div_nb_r[16]};
  assign div_ge    = (div_r2 >= {1'b0, div_d_r});
  assign div_q_new = {div_q_r[15:0], div_ge};

  // square root step
  assign sq_rb   = sqr_r + sqb_r;
  assign sqr_new = (sqv_r >= sq_rb) ? ((sqr_r >> 1) + sqb_r) : (sqr_r >> 1);

  // DDA error terms
  assign err_mq = 19'(err_r) + $signed({3'b000, mq_r});
  assign num_s  = 19'sd32768 - 19'(err_r);
  assign t_sat  = (div_q_r > 17'h10000) ? 17'h10000 : div_q_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    clr_nxt        = clr_r;
    mode_nxt       = mode_r;
    xmaj_nxt       = xmaj_r;
    sm_neg_nxt     = sm_neg_r;
    p_nxt          = p_r;
    p1_nxt         = p1_r;
    n_nxt          = n_r;
    mq_nxt         = mq_r;
    err_nxt        = err_r;
    sum_nxt        = sum_r;
    scale_nxt      = scale_r;
    sqv_nxt        = sqv_r;
    sqr_nxt        = sqr_r;
    sqb_nxt        = sqb_r;
    div_rem_nxt    = div_rem_r;
    div_nb_nxt     = div_nb_r;
    div_q_nxt      = div_q_r;
    div_d_nxt      = div_d_r;
    div_cnt_nxt    = div_cnt_r;
    div_for_t_nxt  = div_for_t_r;
    w_hold_nxt     = w_hold_r;
    t_nxt          = t_r;
    prod_nxt       = prod_r;
    res_cost_nxt   = res_cost_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = cell_addr(sx, sy);
    ram_wdata      = item_r.new_weight[WEIGHT_BITS-1:0];

    // result register drains independently
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // zero sweep after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          state_nxt = S_CHECK;
        end
      end

      // range checks, then branch on action
      S_CHECK: begin
        res_cost_nxt   = '0;
        res_status_nxt = glci_pkg::ST_OK;
        if (item_r.action == glci_pkg::ACT_WRITE) begin
          if (off_s) begin
            res_status_nxt = glci_pkg::ST_OFF_GRID;
            state_nxt      = S_DONE;
          end else if (item_r.new_weight > w_hi) begin
            res_status_nxt = glci_pkg::ST_ABOVE_MAX;
            state_nxt      = S_DONE;
          end else if (item_r.new_weight < min_weight_r) begin
            res_status_nxt = glci_pkg::ST_BELOW_MIN;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_WR_RD;
          end
        end else if (off_s || off_e) begin
          res_status_nxt = glci_pkg::ST_OFF_GRID;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SETUP;
        end
      end

      S_WR_RD: state_nxt = S_WR_UPD;

      // overwrite or keep the larger
      S_WR_UPD: begin
        ram_we    = item_r.overwrite_mode || (item_r.new_weight > rd_w);
        state_nxt = S_DONE;
      end

      // pick walk direction and kind of line
      S_SETUP: begin
        xmaj_nxt   = (ady < adx);
        sm_neg_nxt = ((ex > sx) != (ey > sy));
        if (ady < adx) begin
          p_nxt  = {1'b0, (sx < ex) ? sx : ex};
          p1_nxt = (sx < ex) ? ex : sx;
          n_nxt  = (sx < ex) ? sy : ey;
        end else begin
          p_nxt  = {1'b0, (sy < ey) ? sy : ey};
          p1_nxt = (sy < ey) ? ey : sy;
          n_nxt  = (sy < ey) ? sx : ex;
        end
        err_nxt = '0;
        if (adx == 8'd0 || ady == 8'd0) begin
          mode_nxt  = MODE_AXIS;
          state_nxt = S_START_RD;
        end else if (adx == ady) begin
          mode_nxt  = MODE_DIAG;
          scale_nxt = glci_pkg::DIAG_SCALE;
          state_nxt = S_START_RD;
        end else begin
          // slope = minor * 2^16 / major
          mode_nxt      = MODE_DDA;
          div_rem_nxt   = 16'(minor >> 1);
          div_nb_nxt    = {minor[0], 16'd0};
          div_d_nxt     = {8'd0, major};
          div_q_nxt     = '0;
          div_cnt_nxt   = 5'd16;
          div_for_t_nxt = 1'b0;
          state_nxt     = S_DIV;
        end
      end

      // shared divider, one quotient bit per cycle
      S_DIV: begin
        div_rem_nxt = div_ge ? 16'(div_r2 - {1'b0, div_d_r}) : div_r2[15:0];
        div_nb_nxt  = {div_nb_r[15:0], 1'b0};
        div_q_nxt   = div_q_new;
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd0) begin
          if (div_for_t_r) begin
            state_nxt = S_CROSS1;
          end else begin
            mq_nxt    = (div_q_new[15:0] == 16'd0) ? 16'd1 : div_q_new[15:0];
            state_nxt = S_SQ;
          end
        end
      end

      // 1 + m^2 for the root, error start at m/2
      S_SQ: begin
        sqv_nxt   = 34'h1_0000_0000 + 34'(mq_r * mq_r);
        sqr_nxt   = '0;
        sqb_nxt   = 34'h1_0000_0000;
        err_nxt   = 18'(mq_r >> 1);
        state_nxt = S_SQRT;
      end

      // bit-pair square root
      S_SQRT: begin
        if (sqv_r >= sq_rb) begin
          sqv_nxt = sqv_r - sq_rb;
        end
        sqr_nxt = sqr_new;
        sqb_nxt = sqb_r >> 2;
        if (sqb_r == 34'd1) begin
          scale_nxt = sqr_new[16:0];
          state_nxt = S_START_RD;
        end
      end

      S_START_RD: state_nxt = S_START_ACC;

      // first cell at half weight
      S_START_ACC: begin
        sum_nxt   = 40'(rd_w) << 15;
        p_nxt     = p_r + 9'd1;
        state_nxt = S_STEP_RD;
      end

      // read next interior cell, or the end cell
      S_STEP_RD: begin
        n_nxt     = n_use;
        state_nxt = walk_more ? S_STEP_ACC : S_END_ACC;
      end

      S_STEP_ACC: begin
        if (mode_r == MODE_DDA && err_mq >= 19'sd32768) begin
          // row crossing: fraction t = (0.5 - err) / m
          w_hold_nxt    = rd_w;
          div_rem_nxt   = num_s[16:1];
          div_nb_nxt    = {num_s[0], 16'd0};
          div_d_nxt     = mq_r;
          div_q_nxt     = '0;
          div_cnt_nxt   = 5'd16;
          div_for_t_nxt = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          sum_nxt   = sum_r + (40'(rd_w) << 16);
          err_nxt   = 18'(err_mq);
          p_nxt     = p_r + 9'd1;
          state_nxt = S_STEP_RD;
        end
      end

      // this row gets t, next row read for the rest
      S_CROSS1: begin
        sum_nxt   = sum_r + 40'(w_hold_r * t_sat);
        t_nxt     = t_sat;
        n_nxt     = n_step;
        state_nxt = S_CROSS2;
      end

      S_CROSS2: begin
        sum_nxt   = sum_r + 40'(rd_w * 17'(17'h10000 - t_r));
        err_nxt   = 18'(19'(err_r) - 19'sd65536 + $signed({3'b000, mq_r}));
        p_nxt     = p_r + 9'd1;
        state_nxt = S_STEP_RD;
      end

      // last cell at half weight
      S_END_ACC: begin
        sum_nxt = sum_r + (40'(rd_w) << 15);
        if (mode_r == MODE_AXIS) begin
          res_cost_nxt = (sum_r + (40'(rd_w) << 15)) >> 8;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_SCALE1;
        end
      end

      // sum * scale, low partial product
      S_SCALE1: begin
        prod_nxt  = 41'(sum_r[23:0] * scale_r);
        state_nxt = S_SCALE2;
      end

      // high partial product plus rounded low part
      S_SCALE2: begin
        res_cost_nxt = 40'(sum_r[39:24] * scale_r)
                     + 40'((42'(prod_r) + 42'h80_0000) >> 24);
        state_nxt    = S_DONE;
      end

      // hand result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.line_cost = res_cost_r;
          out_data_nxt.status    = res_status_r;
          state_nxt              = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      min_weight_r <= 16'd0;
      max_weight_r <= 16'hFFFF;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
      min_weight_r <= min_weight_nxt;
      max_weight_r <= max_weight_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    mode_r       <= mode_nxt;
    xmaj_r       <= xmaj_nxt;
    sm_neg_r     <= sm_neg_nxt;
    p_r          <= p_nxt;
    p1_r         <= p1_nxt;
    n_r          <= n_nxt;
    mq_r         <= mq_nxt;
    err_r        <= err_nxt;
    sum_r        <= sum_nxt;
    scale_r      <= scale_nxt;
    sqv_r        <= sqv_nxt;
    sqr_r        <= sqr_nxt;
    sqb_r        <= sqb_nxt;
    div_rem_r    <= div_rem_nxt;
    div_nb_r     <= div_nb_nxt;
    div_q_r      <= div_q_nxt;
    div_d_r      <= div_d_nxt;
    div_cnt_r    <= div_cnt_nxt;
    div_for_t_r  <= div_for_t_nxt;
    w_hold_r     <= w_hold_nxt;
    t_r          <= t_nxt;
    prod_r       <= prod_nxt;
    res_cost_r   <= res_cost_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

/* tb/grid_line_cost_integrator_core_test.sv */
`timescale 1ns / 100ps

module grid_line_cost_integrator_core_test;
  import glci_pkg::*;

  localparam int GW = 256;
  localparam int GH = 256;
  localparam int IDLE_LIMIT = 150000;
  localparam logic [39:0] COST_SAT = 40'hFF_FFFF_FFFF;

  typedef struct {
    logic [COST_BITS-1:0]   cost;
    logic [STATUS_BITS-1:0] status;
  } result_t;

  typedef struct {
    in_item_t               it;
    bit                     pinned;
    logic [COST_BITS-1:0]   cost;
    logic [STATUS_BITS-1:0] status;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  glci_in_if  in_bus();
  glci_out_if out_bus();

  grid_line_cost_integrator_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus.sink), .out_ch(out_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  bit [15:0] weight_mem [0:GW*GH-1];
  int unsigned map_w = 256, map_h = 256, wmin = 0, wmax = 65535;
  result_t result_q[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int hot_x, hot_y;

  // Pinned expectation for the beat being offered
  bit pin_on;
  logic [COST_BITS-1:0] pin_cost;
  logic [STATUS_BITS-1:0] pin_status;

  // Directed table; map 200x100, weights 1..65000
  stim_row_t dir_rows [] = '{
    '{'{ACT_WRITE, 8'd199, 8'd99, 8'd0, 8'd0, 16'd65535, 1'b1}, 1, 40'd0, ST_ABOVE_MAX},
    '{'{ACT_WRITE, 8'd200, 8'd5, 8'd0, 8'd0, 16'd100, 1'b1}, 1, 40'd0, ST_OFF_GRID},
    '{'{ACT_WRITE, 8'd5, 8'd100, 8'd0, 8'd0, 16'd100, 1'b1}, 1, 40'd0, ST_OFF_GRID},
    '{'{ACT_WRITE, 8'd3, 8'd3, 8'd0, 8'd0, 16'd0, 1'b1}, 1, 40'd0, ST_BELOW_MIN},
    '{'{ACT_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0}, 1, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd0, 8'd0, 8'd200, 8'd0, 16'd0, 1'b0}, 1, 40'd0, ST_OFF_GRID},
    '{'{ACT_WRITE, 8'd199, 8'd99, 8'd0, 8'd0, 16'd65000, 1'b1}, 0, 40'd0, ST_OK},
    '{'{ACT_WRITE, 8'd199, 8'd99, 8'd0, 8'd0, 16'd1, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd199, 8'd99, 8'd199, 8'd99, 16'd0, 1'b0}, 1, 40'd16640000, ST_OK},
    '{'{ACT_WRITE, 8'd10, 8'd10, 8'd0, 8'd0, 16'd1000, 1'b1}, 0, 40'd0, ST_OK},
    '{'{ACT_WRITE, 8'd10, 8'd10, 8'd0, 8'd0, 16'd500, 1'b1}, 0, 40'd0, ST_OK},
    '{'{ACT_WRITE, 8'd11, 8'd10, 8'd0, 8'd0, 16'd2000, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_WRITE, 8'd12, 8'd10, 8'd0, 8'd0, 16'd3000, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_WRITE, 8'd10, 8'd11, 8'd0, 8'd0, 16'd4000, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_WRITE, 8'd11, 8'd11, 8'd0, 8'd0, 16'd777, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd10, 8'd10, 8'd12, 8'd10, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd12, 8'd10, 8'd10, 8'd10, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd10, 8'd10, 8'd10, 8'd12, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd10, 8'd10, 8'd12, 8'd12, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd12, 8'd10, 8'd10, 8'd12, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd10, 8'd10, 8'd15, 8'd12, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd10, 8'd10, 8'd11, 8'd15, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd15, 8'd12, 8'd10, 8'd10, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd0, 8'd0, 8'd199, 8'd99, 16'd0, 1'b0}, 0, 40'd0, ST_OK},
    '{'{ACT_QUERY, 8'd0, 8'd99, 8'd199, 8'd0, 16'd0, 1'b0}, 0, 40'd0, ST_OK}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Grid read, zero outside the physical grid
  function automatic longint unsigned grid_wt(int x, int y);
    if (x < 0 || y < 0 || x >= GW || y >= GH) return 0;
    return weight_mem[y*GW + x];
  endfunction

  function automatic longint unsigned walk_wt(bit xmajor, int p, int n);
    return xmajor ? grid_wt(p, n) : grid_wt(n, p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // DDA along the major axis, Q.16 sum with row-crossing split
  function automatic longint unsigned dda_sum(bit xmajor, int p0, int p1, int n, int sm,
                                              longint mq);
    longint unsigned s;
    longint unsigned w;
    longint err, num, t;
    s = walk_wt(xmajor, p0, n) << 15;
    err = mq >>> 1;
    for (int p = p0 + 1; p < p1; p++) begin
      w = walk_wt(xmajor, p, n);
      if (err + mq >= 32768) begin
        num = 32768 - err;
        t = (num <= 0) ? 0 : (num * 65536) / mq;
        if (t > 65536) t = 65536;
        s += w * longint'(t);
        n += sm;
        err -= 65536;
        s += walk_wt(xmajor, p, n) * longint'(65536 - t);
      end else begin
        s += w << 16;
      end
      err += mq;
    end
    s += walk_wt(xmajor, p1, n) << 15;
    return s;
  endfunction

  function automatic logic [39:0] scaled(longint unsigned s, longint unsigned k);
    longint unsigned c;
    c = (s * k + (64'd1 << 23)) >> 24;
    return (c > COST_SAT) ? COST_SAT : c[39:0];
  endfunction

  function automatic logic [39:0] path_cost(int ax, int ay, int bx, int by);
    int dx, dy, adx, ady, sm, lo, hi, major, minor;
    longint unsigned s, k;
    longint mq;
    bit xmajor;
    dx = bx - ax;
    dy = by - ay;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    sm = ((dx > 0) == (dy > 0)) ? 1 : -1;
    if (dx == 0 && dy == 0) return grid_wt(ax, ay) << 8;
    if (dx == 0 || dy == 0) begin
      s = (grid_wt(ax, ay) + grid_wt(bx, by)) << 15;
      if (dx == 0) begin
        lo = (ay < by) ? ay : by;
        hi = (ay < by) ? by : ay;
        for (int i = lo + 1; i < hi; i++) s += grid_wt(ax, i) << 16;
      end else begin
        lo = (ax < bx) ? ax : bx;
        hi = (ax < bx) ? bx : ax;
        for (int i = lo + 1; i < hi; i++) s += grid_wt(i, ay) << 16;
      end
      s = s >> 8;
      return (s > COST_SAT) ? COST_SAT : s[39:0];
    end
    if (adx == ady) begin
      lo = (ax < bx) ? ax : bx;
      hi = (ax < bx) ? ay : by;
      s = (grid_wt(ax, ay) + grid_wt(bx, by)) << 15;
      for (int i = 1; i < adx; i++) s += grid_wt(lo + i, hi + sm*i) << 16;
      return scaled(s, 64'd93061);
    end
    xmajor = ady < adx;
    major = xmajor ? adx : ady;
    minor = xmajor ? ady : adx;
    mq = (longint'(minor) * 65536) / major;
    if (mq < 1) mq = 1;
    k = int_sqrt((64'd1 << 32) + longint'(mq) * longint'(mq));
    if (xmajor) begin
      if (ax < bx) s = dda_sum(1'b1, ax, bx, ay, sm, mq);
      else s = dda_sum(1'b1, bx, ax, by, sm, mq);
    end else begin
      if (ay < by) s = dda_sum(1'b0, ay, by, ax, sm, mq);
      else s = dda_sum(1'b0, by, ay, bx, sm, mq);
    end
    return scaled(s, k);
  endfunction

  // Work out one result and apply a write to the grid copy
  function automatic result_t predict_item(in_item_t it);
    result_t r;
    int unsigned aw, ah, idx;
    aw = (map_w < GW) ? map_w : GW;
    ah = (map_h < GH) ? map_h : GH;
    r.cost = '0;
    r.status = ST_OK;
    if (it.action == ACT_WRITE) begin
      if (it.start_x >= aw || it.start_y >= ah) r.status = ST_OFF_GRID;
      else if (it.new_weight > wmax) r.status = ST_ABOVE_MAX;
      else if (it.new_weight < wmin) r.status = ST_BELOW_MIN;
      else begin
        idx = it.start_y * GW + it.start_x;
        if (it.overwrite_mode || it.new_weight > weight_mem[idx])
          weight_mem[idx] = it.new_weight;
      end
    end else if (it.start_x >= aw || it.start_y >= ah || it.end_x >= aw || it.end_y >= ah) begin
      r.status = ST_OFF_GRID;
    end else begin
      r.cost = path_cost(it.start_x, it.start_y, it.end_x, it.end_y);
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Input monitor: predict on every accepted beat
  always @(posedge clk) begin
    result_t r;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      r = predict_item(in_bus.data);
      if (pin_on) begin
        r.cost = pin_cost;
        r.status = pin_status;
      end
      result_q.push_back(r);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected result beat", out_bus.data, 0);
      end else begin
        e = result_q.pop_front();
        if (out_bus.data.line_cost !== e.cost) report("line_cost", out_bus.data.line_cost, e.cost);
        if (out_bus.data.status !== e.status) report("status", out_bus.data.status, e.status);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[grid_line_cost_integrator_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Receiver stalls
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 8))
        @(negedge clk) out_bus.ready <= 1'b1;
      repeat (gap_len()) @(negedge clk) out_bus.ready <= 1'b0;
    end
  end

  task automatic send_beat(in_item_t it, bit pin, logic [39:0] c, logic [1:0] st);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= it;
    pin_on = pin;
    pin_cost = c;
    pin_status = st;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk) in_bus.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, int unsigned v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAP_WIDTH:  map_w = v & 32'h1FF;
      REG_MAP_HEIGHT: map_h = v & 32'h1FF;
      REG_MIN_WEIGHT: wmin = v & 32'hFFFF;
      default:        wmax = v & 32'hFFFF;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_map(int unsigned w, int unsigned h, int unsigned lo, int unsigned hi);
    drain();
    reg_write(REG_MAP_WIDTH, w);
    reg_write(REG_MAP_HEIGHT, h);
    reg_write(REG_MIN_WEIGHT, lo);
    reg_write(REG_MAX_WEIGHT, hi);
    hot_x = $urandom_range(0, 240);
    hot_y = $urandom_range(0, 240);
  endtask

  // Coordinate: mostly inside a hot window so queries see written cells
  function automatic int pick_coord(int unsigned lim, int hot);
    int v, r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 5) return $urandom_range(0, 255);
    if (lim > GW) lim = GW;
    if (r < 15) return $urandom_range(0, lim - 1);
    v = hot + $urandom_range(0, 15);
    return (v > int'(lim) - 1) ? (v % lim) : v;
  endfunction

  function automatic int near_coord(int c, int unsigned lim);
    int v;
    v = c + $urandom_range(0, 16) - 8;
    if ($urandom_range(0, 3) == 0) v = c;
    if (v < 0) v = 0;
    if (lim > 0 && v > int'(lim) - 1 && lim <= GW) v = lim - 1;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int r, d;
    it.action = $urandom_range(0, 1) ? ACT_QUERY : ACT_WRITE;
    it.start_x = pick_coord(map_w, hot_x);
    it.start_y = pick_coord(map_h, hot_y);
    it.end_x = near_coord(it.start_x, map_w);
    it.end_y = near_coord(it.start_y, map_h);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.end_x = pick_coord(map_w, 0);
      it.end_y = pick_coord(map_h, 0);
    end else if (r < 20) begin
      // 45-degree line
      d = int'(it.end_x) - int'(it.start_x);
      d = (d < 0) ? -d : d;
      if (it.start_y + d <= 255) it.end_y = it.start_y + d;
      else it.end_y = it.start_y - d;
    end
    r = $urandom_range(0, 99);
    if (r < 10) it.new_weight = wmin;
    else if (r < 20) it.new_weight = wmax;
    else if (r < 25) it.new_weight = 16'd0;
    else if (r < 30) it.new_weight = 16'hFFFF;
    else it.new_weight = $urandom_range(0, 65535);
    it.overwrite_mode = $urandom_range(0, 1);
    return it;
  endfunction

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pin_on = 1'b0;
    pin_cost = '0;
    pin_status = ST_OK;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset values: empty grid, single-cell query and corner-to-corner diagonal
    it = '{ACT_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 16'd0, 1'b0};
    send_beat(it, 1'b1, 40'd0, ST_OK);
    it = '{ACT_QUERY, 8'd0, 8'd255, 8'd255, 8'd0, 16'd0, 1'b0};
    send_beat(it, 1'b0, 40'd0, ST_OK);

    // Directed table
    set_map(200, 100, 1, 65000);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].cost, dir_rows[i].status);

    // Random phases over several settings, extremes first
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_map(256, 256, 0, 65535);
        1: set_map(511, 511, 0, 65535);
        2: set_map(16, 16, 100, 60000);
        3: set_map(1, 1, 0, 65535);
        4: set_map(0, 5, 0, 65535);
        5: set_map(255, 255, 40000, 20000);
        6: set_map(8, 200, 65535, 65535);
        7: set_map(200, 8, 0, 0);
        default: set_map($urandom_range(1, 511), $urandom_range(1, 511),
                         $urandom_range(0, 300), $urandom_range(30000, 65535));
      endcase
      repeat (130) send_beat(rand_item(), 1'b0, 40'd0, ST_OK);
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("[grid_line_cost_integrator_core] OK");
    end else begin
      $display("[grid_line_cost_integrator_core] ERROR");
    end
    $finish;
  end

endmodule
